>>> design/heightmap_normal_encoder_core_assert.svh
// Assertion macros shared by the heightmap normal encoder checkers.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef HEIGHTMAP_NORMAL_ENCODER_CORE_ASSERT_SVH
`define HEIGHTMAP_NORMAL_ENCODER_CORE_ASSERT_SVH

// When cond holds at one edge, sig must be unchanged at the next.
`define HNE_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("hold check failed");

// When cond holds, expr must hold in the same cycle.
`define HNE_ASSERT_IMPL(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("implication check failed");

`endif

>>> design/hne_pkg.sv
// Shared types and constants of the heightmap normal encoder.
// No dependencies; imported by every module of the block.
package hne_pkg;

    localparam int RES_W   = 13;
    localparam int K_W     = 24;
    localparam int IDX_W   = 12;
    localparam int H_W     = 32;
    localparam int DIFF_W  = H_W + 1;
    localparam int PROD_W  = DIFF_W + K_W + 1;
    localparam int SLOPE_W = 28;
    localparam int SUM_W   = 2 * SLOPE_W;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int RT_W    = SUM_W + 1;
    localparam int NUM_W   = ROOT_W + 1;
    localparam int BYTE_W  = 8;
    localparam int DIV_W   = NUM_W + BYTE_W + 1;
    localparam int ONE_Q16 = 65536;

    localparam logic [PROD_W-1:0] SLOPE_POS_LIM = PROD_W'((64'd1 << (SLOPE_W - 1)) - 64'd1);
    localparam logic [PROD_W-1:0] SLOPE_NEG_LIM = PROD_W'(64'd1 << (SLOPE_W - 1));
    localparam logic [SUM_W-1:0]  UNIT_SQ       = SUM_W'(64'd1 << 32);

    typedef enum logic [0:0] {
        CFG_GRID_RES = 1'b0,
        CFG_INV_CELL = 1'b1
    } cfg_idx_t;

    // Data that travels alongside the arithmetic once the slopes are known.
    typedef struct packed {
        logic signed [H_W-1:0]     height;
        logic signed [SLOPE_W-1:0] nx;
        logic signed [SLOPE_W-1:0] nz;
    } side_t;

endpackage

>>> design/heightmap_normal_encoder_core.sv
// Heightmap normal encoder, top level. An accepted item passes to its result through
// three gradient stages, sixteen square root stages and five encode stages.
// Throughput is one item per cycle; the whole pipeline advances together and holds
// while the result register is stalled. Reset clears all valid bits and sets
// grid_resolution to 256 and inverse_cell_size to 1.0; it needs no clearing pass.
// Depends on hne_pkg, hne_gradient, hne_isqrt and hne_encode.
module heightmap_normal_encoder_core
    import hne_pkg::*;
#(
    parameter int MAX_RESOLUTION = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [IDX_W-1:0]  column,
    input  logic [IDX_W-1:0]  row,
    input  logic [H_W-1:0]    height_center,
    input  logic [H_W-1:0]    height_left,
    input  logic [H_W-1:0]    height_right,
    input  logic [H_W-1:0]    height_above,
    input  logic [H_W-1:0]    height_below,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [H_W-1:0]    height_out,
    output logic [BYTE_W-1:0] normal_x_byte,
    output logic [BYTE_W-1:0] normal_y_byte,
    output logic [BYTE_W-1:0] normal_z_byte,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  cfg_idx_t          cfg_index,
    input  logic [K_W-1:0]    cfg_data
);

    localparam int MAXR_W = $clog2(MAX_RESOLUTION + 1);
    localparam int LAST_W = (MAXR_W > RES_W) ? MAXR_W : RES_W;
    localparam logic [LAST_W-1:0] MAX_RES = LAST_W'(MAX_RESOLUTION);

    logic [RES_W-1:0]  grid_res_reg;
    logic [K_W-1:0]    inv_cell_reg;
    logic [LAST_W-1:0] res_clamped;
    logic              has_last;
    logic [LAST_W-1:0] last_idx;
    logic              en;
    logic              g_valid, s_valid;
    side_t             g_side, s_side;
    logic [ROOT_W-1:0] s_root;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_res_reg <= RES_W'(256);
            inv_cell_reg <= K_W'(ONE_Q16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRID_RES: grid_res_reg <= cfg_data[RES_W-1:0];
                CFG_INV_CELL: inv_cell_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign res_clamped = (LAST_W'(grid_res_reg) > MAX_RES) ? MAX_RES : LAST_W'(grid_res_reg);
    assign has_last    = (res_clamped != '0);
    assign last_idx    = res_clamped - LAST_W'(1);

    assign en         = !(result_valid && result_stall);
    assign item_stall = !en;

    hne_gradient #(
        .LAST_W (LAST_W)
    ) u_gradient (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (item_valid),
        .column        (column),
        .row           (row),
        .height_center (height_center),
        .height_left   (height_left),
        .height_right  (height_right),
        .height_above  (height_above),
        .height_below  (height_below),
        .has_last      (has_last),
        .last_idx      (last_idx),
        .inv_cell      (inv_cell_reg),
        .out_valid     (g_valid),
        .out_side      (g_side)
    );

    hne_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid),
        .in_side   (g_side),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_side  (s_side)
    );

    hne_encode u_encode (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_valid),
        .in_root    (s_root),
        .in_side    (s_side),
        .out_valid  (result_valid),
        .out_height (height_out),
        .out_x      (normal_x_byte),
        .out_y      (normal_y_byte),
        .out_z      (normal_z_byte)
    );

endmodule

>>> design/hne_gradient.sv
// Gradient stages: edge selection and differences, scaling multiply, shift and saturate.
// Depends on hne_pkg.
module hne_gradient
    import hne_pkg::*;
#(
    parameter int LAST_W = 13
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IDX_W-1:0]    column,
    input  logic [IDX_W-1:0]    row,
    input  logic [H_W-1:0]      height_center,
    input  logic [H_W-1:0]      height_left,
    input  logic [H_W-1:0]      height_right,
    input  logic [H_W-1:0]      height_above,
    input  logic [H_W-1:0]      height_below,
    input  logic                has_last,
    input  logic [LAST_W-1:0]   last_idx,
    input  logic [K_W-1:0]      inv_cell,
    output logic                out_valid,
    output side_t               out_side
);

    logic                     col_first, col_last, row_first, row_last;
    logic signed [DIFF_W-1:0] hc, hl, hr, ha, hb;
    logic signed [DIFF_W-1:0] dx_next, dz_next;
    logic                     shx_next, shz_next;

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] dx_reg, dz_reg;
    logic                     shx1_reg, shz1_reg, shx2_reg, shz2_reg;
    logic [H_W-1:0]           h1_reg, h2_reg, h3_reg;
    logic signed [PROD_W-1:0] px_next, pz_next, px_reg, pz_reg;
    logic signed [SLOPE_W-1:0] nx_reg, nz_reg;

    function automatic logic signed [SLOPE_W-1:0] sat_slope(
        input logic signed [PROD_W-1:0] p,
        input logic                     half
    );
        logic              neg;
        logic [PROD_W-1:0] mag;
        neg = p[PROD_W-1];
        mag = neg ? PROD_W'(-p) : PROD_W'(p);
        mag = half ? (mag >> 17) : (mag >> 16);
        if (neg)
        begin
            if (mag > SLOPE_NEG_LIM)
            begin
                mag = SLOPE_NEG_LIM;
            end
            return SLOPE_W'(PROD_W'(-mag));
        end
        if (mag > SLOPE_POS_LIM)
        begin
            mag = SLOPE_POS_LIM;
        end
        return SLOPE_W'(mag);
    endfunction

    assign hc = {height_center[H_W-1], height_center};
    assign hl = {height_left[H_W-1], height_left};
    assign hr = {height_right[H_W-1], height_right};
    assign ha = {height_above[H_W-1], height_above};
    assign hb = {height_below[H_W-1], height_below};

    assign col_first = (column == '0);
    assign row_first = (row == '0);
    assign col_last  = has_last && (LAST_W'(column) == last_idx);
    assign row_last  = has_last && (LAST_W'(row) == last_idx);

    // The first edge wins when an index is both first and last.
    always_comb
    begin
        if (col_first)
        begin
            dx_next  = hr - hc;
            shx_next = 1'b0;
        end
        else if (col_last)
        begin
            dx_next  = hc - hl;
            shx_next = 1'b0;
        end
        else
        begin
            dx_next  = hr - hl;
            shx_next = 1'b1;
        end
        if (row_first)
        begin
            dz_next  = hc - hb;
            shz_next = 1'b0;
        end
        else if (row_last)
        begin
            dz_next  = ha - hc;
            shz_next = 1'b0;
        end
        else
        begin
            dz_next  = ha - hb;
            shz_next = 1'b1;
        end
    end

    assign px_next = dx_reg * $signed({1'b0, inv_cell});
    assign pz_next = dz_reg * $signed({1'b0, inv_cell});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= dx_next;
            dz_reg   <= dz_next;
            shx1_reg <= shx_next;
            shz1_reg <= shz_next;
            h1_reg   <= height_center;
            px_reg   <= px_next;
            pz_reg   <= pz_next;
            shx2_reg <= shx1_reg;
            shz2_reg <= shz1_reg;
            h2_reg   <= h1_reg;
            nx_reg   <= sat_slope(px_reg, shx2_reg);
            nz_reg   <= sat_slope(pz_reg, shz2_reg);
            h3_reg   <= h2_reg;
        end
    end

    assign out_valid       = v3_reg;
    assign out_side.height = h3_reg;
    assign out_side.nx     = nx_reg;
    assign out_side.nz     = nz_reg;

endmodule

>>> design/hne_isqrt.sv
// Squares the slopes, adds one, and takes a pipelined integer square root,
// two result bits per stage. Depends on hne_pkg.
module hne_isqrt
    import hne_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output side_t             out_side
);

    localparam int SQ_ST = ROOT_W / 2;

    typedef struct packed {
        logic [SUM_W-1:0] x;
        logic [RT_W-1:0]  r;
    } sq_t;

    logic                      va_reg;
    logic signed [SUM_W-1:0]   sqx_reg, sqz_reg;
    side_t                     sa_reg;
    logic [SQ_ST:0]            v_reg;
    logic [SUM_W-1:0]          x_reg [SQ_ST+1];
    logic [RT_W-1:0]           r_reg [SQ_ST+1];
    side_t                     side_reg [SQ_ST+1];
    sq_t                       step_out [SQ_ST];

    function automatic sq_t sq_step(input sq_t s, input logic [RT_W-1:0] b);
        sq_t             o;
        logic [RT_W-1:0] t;
        t = s.r + b;
        if ({1'b0, s.x} >= t)
        begin
            o.x = s.x - SUM_W'(t);
            o.r = (s.r >> 1) + b;
        end
        else
        begin
            o.x = s.x;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    for (genvar s = 0; s < SQ_ST; s++)
    begin : g_step
        sq_t a, c;
        always_comb
        begin
            a.x = x_reg[s];
            a.r = r_reg[s];
            c   = sq_step(a, RT_W'(1) << (SUM_W - 2 - 4 * s));
            step_out[s] = sq_step(c, RT_W'(1) << (SUM_W - 4 - 4 * s));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            v_reg  <= '0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            v_reg  <= {v_reg[SQ_ST-1:0], va_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg     <= in_side.nx * in_side.nx;
            sqz_reg     <= in_side.nz * in_side.nz;
            sa_reg      <= in_side;
            x_reg[0]    <= $unsigned(sqx_reg) + $unsigned(sqz_reg) + UNIT_SQ;
            r_reg[0]    <= '0;
            side_reg[0] <= sa_reg;
            for (int s = 0; s < SQ_ST; s++)
            begin
                x_reg[s+1]    <= step_out[s].x;
                r_reg[s+1]    <= step_out[s].r;
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = v_reg[SQ_ST];
    assign out_root  = r_reg[SQ_ST][ROOT_W-1:0];
    assign out_side  = side_reg[SQ_ST];

endmodule

>>> design/hne_encode.sv
// Byte encoding: offsets each component by the length, scales it by 255 and divides by
// twice the length in three pipelined restoring dividers. Depends on hne_pkg.
module hne_encode
    import hne_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] in_root,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [H_W-1:0]    out_height,
    output logic [BYTE_W-1:0] out_x,
    output logic [BYTE_W-1:0] out_y,
    output logic [BYTE_W-1:0] out_z
);

    localparam int DIV_ST = BYTE_W / 2;
    localparam int LANES  = 3;

    logic [NUM_W:0]      cx, cy, cz;
    logic [NUM_W-1:0]    num [LANES];
    logic [DIV_ST:0]     v_reg;
    logic [DIV_W-1:0]    rem_reg [DIV_ST+1][LANES];
    logic [BYTE_W-1:0]   q_reg [DIV_ST+1][LANES];
    logic [NUM_W-1:0]    den_reg [DIV_ST+1];
    logic [H_W-1:0]      h_reg [DIV_ST+1];
    logic [DIV_W-1:0]    rem_step [DIV_ST][LANES];
    logic [BYTE_W-1:0]   q_step [DIV_ST][LANES];

    // Every offset component is non-negative, since the length exceeds any slope.
    assign cx = {{(NUM_W + 1 - SLOPE_W){in_side.nx[SLOPE_W-1]}}, in_side.nx}
                + {2'b00, in_root};
    assign cy = (NUM_W + 1)'(ONE_Q16) + {2'b00, in_root};
    assign cz = {{(NUM_W + 1 - SLOPE_W){in_side.nz[SLOPE_W-1]}}, in_side.nz}
                + {2'b00, in_root};
    assign num[0] = cx[NUM_W-1:0];
    assign num[1] = cy[NUM_W-1:0];
    assign num[2] = cz[NUM_W-1:0];

    for (genvar s = 0; s < DIV_ST; s++)
    begin : g_div
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            always_comb
            begin
                logic [DIV_W-1:0] r;
                logic [DIV_W-1:0] d_hi, d_lo;
                logic [BYTE_W-1:0] q;
                r    = rem_reg[s][l];
                q    = q_reg[s][l];
                d_hi = DIV_W'(den_reg[s]) << (BYTE_W - 1 - 2 * s);
                d_lo = DIV_W'(den_reg[s]) << (BYTE_W - 2 - 2 * s);
                if (r >= d_hi)
                begin
                    r = r - d_hi;
                    q[BYTE_W-1-2*s] = 1'b1;
                end
                if (r >= d_lo)
                begin
                    r = r - d_lo;
                    q[BYTE_W-2-2*s] = 1'b1;
                end
                rem_step[s][l] = r;
                q_step[s][l]   = q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DIV_ST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                // num times 255 without a multiplier.
                rem_reg[0][l] <= DIV_W'({num[l], {BYTE_W{1'b0}}}) - DIV_W'(num[l]);
                q_reg[0][l]   <= '0;
            end
            den_reg[0] <= {in_root, 1'b0};
            h_reg[0]   <= in_side.height;
            for (int s = 0; s < DIV_ST; s++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s+1][l] <= rem_step[s][l];
                    q_reg[s+1][l]   <= q_step[s][l];
                end
                den_reg[s+1] <= den_reg[s];
                h_reg[s+1]   <= h_reg[s];
            end
        end
    end

    assign out_valid  = v_reg[DIV_ST];
    assign out_height = h_reg[DIV_ST];
    assign out_x      = q_reg[DIV_ST][0];
    assign out_y      = q_reg[DIV_ST][1];
    assign out_z      = q_reg[DIV_ST][2];

endmodule

>>> design/hne_checker.sv
// Port-level checks for the heightmap normal encoder, bound to the top level.
// Depends on hne_pkg and the assertion macro header.
`include "heightmap_normal_encoder_core_assert.svh"

module hne_checker
    import hne_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input logic [BYTE_W-1:0] normal_x_byte,
    input logic [BYTE_W-1:0] normal_y_byte,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    // A stalled result keeps its x component byte.
    `HNE_ASSERT_HOLD(a_result_hold, clk, rst_n, result_valid && result_stall, normal_x_byte)
    // The input side is held back only by a stalled result.
    `HNE_ASSERT_IMPL(a_stall_cause, clk, rst_n, item_stall, result_valid && result_stall)
    // The up component is never below the horizontal half of the code range.
    `HNE_ASSERT_IMPL(a_y_range, clk, rst_n, result_valid, normal_y_byte >= 8'd127)
    // Register writes are never refused.
    `HNE_ASSERT_IMPL(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind heightmap_normal_encoder_core hne_checker u_hne_checker (.*);

>>> test/heightmap_normal_encoder_core_test.sv
// Self-checking testbench for the heightmap normal encoder core.
// Depends on hne_pkg and heightmap_normal_encoder_core; predicts each normal in-line.
`timescale 1ns / 1ps

module heightmap_normal_encoder_core_test;
    import hne_pkg::*;

    typedef struct {
        logic [11:0] col;
        logic [11:0] rw;
        logic [31:0] hc, hl, hr, ha, hb;
    } point_t;

    typedef struct {
        logic [31:0] h;
        logic [7:0]  bx, by, bz;
    } normal_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [11:0] column = '0, row = '0;
    logic [31:0] height_center = '0, height_left = '0, height_right = '0;
    logic [31:0] height_above = '0, height_below = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [31:0] height_out;
    logic [7:0] normal_x_byte, normal_y_byte, normal_z_byte;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_idx_t cfg_index = CFG_GRID_RES;
    logic [23:0] cfg_data = '0;

    point_t  pending_points[$];
    normal_t expected_normals[$];
    longint  res_cur = 256, inv_cell = 65536;
    int      mismatches = 0, checked = 0, gap = 0, hold = 0;
    longint  cycles = 0;
    bit      drive_on = 1'b0;
    // Handshakes seen at the last rising edge, for the driver at the next falling edge.
    bit      in_taken = 1'b0, out_taken = 1'b0;

    heightmap_normal_encoder_core u_top (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint grad(longint diff, int sh);
        longint p, mag;
        begin
            p = diff * inv_cell;
            mag = (p < 0) ? -p : p;
            mag = mag >>> sh;
            if (p < 0)
            begin
                if (mag > 64'h8000000) mag = 64'h8000000;
                return -mag;
            end
            if (mag > 64'h7FFFFFF) mag = 64'h7FFFFFF;
            return mag;
        end
    endfunction

    function automatic longint root64(longint unsigned x);
        longint unsigned r, b;
        begin
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else r = r >> 1;
                b = b >> 2;
            end
            return r;
        end
    endfunction

    function automatic logic [7:0] to_byte(longint c, longint len);
        longint unsigned num;
        begin
            num = c + len;
            return 8'((num * 255) / (len * 2));
        end
    endfunction

    function automatic normal_t predict_normal(point_t p);
        longint hc, hl, hr, ha, hb, rs, last, nx, nz, len;
        normal_t n;
        begin
            hc = longint'($signed(p.hc)); hl = longint'($signed(p.hl));
            hr = longint'($signed(p.hr)); ha = longint'($signed(p.ha));
            hb = longint'($signed(p.hb));
            rs = (res_cur > 4096) ? 4096 : res_cur;
            last = rs - 1;
            if (p.col == 0) nx = grad(hr - hc, 16);
            else if (rs != 0 && p.col == last) nx = grad(hc - hl, 16);
            else nx = grad(hr - hl, 17);
            if (p.rw == 0) nz = grad(hc - hb, 16);
            else if (rs != 0 && p.rw == last) nz = grad(ha - hc, 16);
            else nz = grad(ha - hb, 17);
            len = root64(nx * nx + nz * nz + (64'd1 << 32));
            n.h = p.hc;
            n.bx = to_byte(nx, len);
            n.by = to_byte(65536, len);
            n.bz = to_byte(nz, len);
            return n;
        end
    endfunction

    // Driver: draws a random gap, possibly empty, before each item.
    always @(negedge clk)
    begin
        if (in_taken)
        begin
            void'(pending_points.pop_front());
            gap = $urandom_range(0, 3);
        end
        if (drive_on && pending_points.size() > 0 && gap == 0)
        begin
            item_valid <= 1'b1;
            column <= pending_points[0].col;
            row <= pending_points[0].rw;
            height_center <= pending_points[0].hc;
            height_left <= pending_points[0].hl;
            height_right <= pending_points[0].hr;
            height_above <= pending_points[0].ha;
            height_below <= pending_points[0].hb;
        end
        else
        begin
            item_valid <= 1'b0;
            if (gap > 0) gap = gap - 1;
        end
        if (out_taken) hold = $urandom_range(0, 3);
        if (hold > 0)
        begin
            result_stall <= 1'b1;
            hold = hold - 1;
        end
        else result_stall <= 1'b0;
    end

    // Monitor: predicts on item acceptance, checks on result acceptance.
    always @(posedge clk)
    begin
        normal_t e;
        in_taken = rst_n && item_valid && !item_stall;
        out_taken = rst_n && result_valid && !result_stall;
        cycles <= cycles + 1;
        if (in_taken)
            expected_normals.push_back(predict_normal(pending_points[0]));
        if (out_taken)
        begin
            if (expected_normals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item");
            end
            else
            begin
                e = expected_normals.pop_front();
                checked++;
                if (e.h !== height_out || e.bx !== normal_x_byte ||
                    e.by !== normal_y_byte || e.bz !== normal_z_byte)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp h=%h x=%0d y=%0d z=%0d got h=%h x=%0d y=%0d z=%0d",
                                 e.h, e.bx, e.by, e.bz, height_out, normal_x_byte,
                                 normal_y_byte, normal_z_byte);
                end
            end
        end
        if (cycles > 400000)
        begin
            $display("timeout");
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            if (idx == CFG_GRID_RES) res_cur = val & 24'h1FFF;
            else inv_cell = val;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic run_points();
        begin
            drive_on = 1'b1;
            while (pending_points.size() > 0 || expected_normals.size() > 0)
                @(posedge clk);
            drive_on = 1'b0;
            repeat (30) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_height();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [11:0] rand_index(int rs);
        int last;
        begin
            last = (rs > 4096 || rs == 0) ? 4095 : rs - 1;
            case ($urandom_range(0, 5))
                0: return 12'd0;
                1: return 12'(last);
                2: return 12'($urandom);
                default: return 12'($urandom_range(0, last));
            endcase
        end
    endfunction

    task automatic add_random(int count);
        point_t p;
        begin
            repeat (count)
            begin
                p.col = rand_index(res_cur); p.rw = rand_index(res_cur);
                p.hc = rand_height(); p.hl = rand_height(); p.hr = rand_height();
                p.ha = rand_height(); p.hb = rand_height();
                pending_points.push_back(p);
            end
        end
    endtask

    initial
    begin
        point_t p;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // Directed: corners, edges, extremes, flat ground, unused neighbours.
        p = '{12'd0, 12'd0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0};
        pending_points.push_back(p);
        p = '{12'd255, 12'd255, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0};
        pending_points.push_back(p);
        p = '{12'd0, 12'd255, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0};
        pending_points.push_back(p);
        p = '{12'd100, 12'd7, 32'h1_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000};
        pending_points.push_back(p);
        p = '{12'hFFF, 12'hFFF, 32'h5, 32'h3_0000, 32'h1_0000, 32'h0, 32'h2_0000};
        pending_points.push_back(p);
        p = '{12'd3, 12'd4, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
              32'h1234_5678, 32'h1234_5678};
        pending_points.push_back(p);
        add_random(60);
        run_points();
        write_reg(CFG_INV_CELL, 24'd0);
        write_reg(CFG_GRID_RES, 24'd2);
        add_random(40);
        run_points();
        write_reg(CFG_INV_CELL, 24'hFF_FFFF);
        write_reg(CFG_GRID_RES, 24'd4096);
        add_random(80);
        run_points();
        write_reg(CFG_INV_CELL, 24'd3);
        write_reg(CFG_GRID_RES, 24'd0);
        add_random(40);
        run_points();
        write_reg(CFG_INV_CELL, 24'($urandom));
        write_reg(CFG_GRID_RES, 24'h1FFF);
        add_random(60);
        run_points();
        write_reg(CFG_INV_CELL, 24'd32768);
        write_reg(CFG_GRID_RES, 24'd1);
        add_random(40);
        run_points();
        write_reg(CFG_INV_CELL, 24'($urandom_range(1, 200000)));
        write_reg(CFG_GRID_RES, 24'($urandom_range(2, 64)));
        add_random(90);
        run_points();
        $display("Checked %0d normals over seven register settings, %0d mismatches.",
                 checked, mismatches);
        if (mismatches == 0 && expected_normals.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

>>> sim.f
+incdir+design
design/hne_pkg.sv
design/hne_gradient.sv
design/hne_isqrt.sv
design/hne_encode.sv
design/heightmap_normal_encoder_core.sv
design/hne_checker.sv
test/heightmap_normal_encoder_core_test.sv
